/* hw/rtl/epoch_to_calendar_date_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the epoch to calendar date block
// Shared property forms, clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef EPOCH_TO_CALENDAR_DATE_ASSERT_SVH
`define EPOCH_TO_CALENDAR_DATE_ASSERT_SVH

// Same-cycle implication
`define E2C_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("e2c check failed");

// Next-cycle implication
`define E2C_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("e2c check failed");

`endif

/* hw/rtl/e2c_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// e2c_pkg
// Types and constants shared by the epoch to calendar date controller and
// datapath: reciprocal constants, calendar constants, command and status.
// ----------------------------------------------------------------------------
package e2c_pkg;

  // Reciprocal multipliers: q = (t * MUL) >> SHIFT, exact for any 32-bit t
  localparam logic [31:0] DIV60_MUL   = 32'h8888_8889;
  localparam int          DIV60_SHIFT = 37;
  localparam logic [31:0] DIV24_MUL   = 32'hAAAA_AAAB;
  localparam int          DIV24_SHIFT = 36;
  localparam logic [31:0] DIV60       = 32'd60;
  localparam logic [31:0] DIV24       = 32'd24;

  // Calendar constants
  localparam logic [11:0] BASE_YEAR    = 12'd1970;
  localparam logic [6:0]  BASE_MOD100  = 7'd70;
  localparam logic [8:0]  BASE_MOD400  = 9'd370;
  localparam logic [6:0]  LAST_MOD100  = 7'd99;
  localparam logic [8:0]  LAST_MOD400  = 9'd399;
  localparam logic [8:0]  LEAP_SPAN    = 9'd366;
  localparam logic [8:0]  COMMON_SPAN  = 9'd365;
  localparam logic [3:0]  MONTH_JAN    = 4'd0;
  localparam logic [3:0]  MONTH_FEB    = 4'd1;
  localparam logic [3:0]  MONTH_DEC    = 4'd11;

  // Which quotient/remainder pass the datapath runs
  typedef enum logic [1:0] {
    DIV_SEC,
    DIV_MIN,
    DIV_HOUR
  } div_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic     load;
    logic     div_mul;
    logic     div_rem;
    div_sel_t div_sel;
    logic     year_step;
    logic     month_step;
    logic     publish;
  } e2c_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic year_fit;
    logic month_fit;
  } e2c_sts_t;

  // Days in a month, month counted from zero
  function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    unique case (mon)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
      4'd3, 4'd5, 4'd8, 4'd10:                   len = 5'd30;
      MONTH_FEB:                                 len = leap ? 5'd29 : 5'd28;
      default:                                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/e2c_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// e2c_datapath
// Work registers, reciprocal divider, year and month subtract units and the
// output register of the epoch to calendar date converter.
// ----------------------------------------------------------------------------
module e2c_datapath (
  input  wire logic             clk,
  input  wire logic [31:0]      epoch_seconds,
  input  wire e2c_pkg::e2c_cmd_t cmd,
  output e2c_pkg::e2c_sts_t     sts,
  output logic [11:0]           year,
  output logic [3:0]            month,
  output logic [4:0]            day,
  output logic [4:0]            hour,
  output logic [5:0]            minute,
  output logic [5:0]            second
);

  logic [31:0] work_t;
  logic [63:0] prod;
  logic [5:0]  work_sec;
  logic [5:0]  work_min;
  logic [4:0]  work_hour;
  logic [15:0] days;
  logic [11:0] work_year;
  logic [6:0]  mod100;
  logic [8:0]  mod400;
  logic [3:0]  mon;

  logic [31:0] mul_k;
  logic [26:0] q60;
  logic [27:0] q24;
  logic [31:0] rem60;
  logic [31:0] rem24;
  logic        leap;
  logic [8:0]  year_span;
  logic [4:0]  mon_span;

  // Select the reciprocal for the current pass
  assign mul_k = (cmd.div_sel == e2c_pkg::DIV_HOUR) ? e2c_pkg::DIV24_MUL
                                                    : e2c_pkg::DIV60_MUL;

  // Quotients from the registered product, remainders by back-multiply
  assign q60   = prod[63:e2c_pkg::DIV60_SHIFT];
  assign q24   = prod[63:e2c_pkg::DIV24_SHIFT];
  assign rem60 = work_t - (32'(q60) * e2c_pkg::DIV60);
  assign rem24 = work_t - (32'(q24) * e2c_pkg::DIV24);

  // Leap rule from the year's low bits and the running remainders
  assign leap = ((work_year[1:0] == 2'd0) && (mod100 != 7'd0)) || (mod400 == 9'd0);
  assign year_span = leap ? e2c_pkg::LEAP_SPAN : e2c_pkg::COMMON_SPAN;
  assign mon_span  = e2c_pkg::month_days(mon, leap);

  // Report whether the remaining days stop the year or month walk
  assign sts.year_fit  = days < 16'(year_span);
  assign sts.month_fit = (days < 16'(mon_span)) || (mon == e2c_pkg::MONTH_DEC);

  // Advance the work registers on controller commands
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      work_t    <= epoch_seconds;
      work_year <= e2c_pkg::BASE_YEAR;
      mod100    <= e2c_pkg::BASE_MOD100;
      mod400    <= e2c_pkg::BASE_MOD400;
      mon       <= e2c_pkg::MONTH_JAN;
    end
    if (cmd.div_mul) begin
      prod <= 64'(work_t) * 64'(mul_k);
    end
    if (cmd.div_rem) begin
      unique case (cmd.div_sel)
        e2c_pkg::DIV_SEC: begin
          work_sec <= rem60[5:0];
          work_t   <= 32'(q60);
        end
        e2c_pkg::DIV_MIN: begin
          work_min <= rem60[5:0];
          work_t   <= 32'(q60);
        end
        e2c_pkg::DIV_HOUR: begin
          work_hour <= rem24[4:0];
          days      <= q24[15:0];
        end
        default: begin
          work_t <= work_t;
        end
      endcase
    end
    if (cmd.year_step) begin
      days      <= days - 16'(year_span);
      work_year <= work_year + 12'd1;
      mod100    <= (mod100 == e2c_pkg::LAST_MOD100) ? 7'd0 : mod100 + 7'd1;
      mod400    <= (mod400 == e2c_pkg::LAST_MOD400) ? 9'd0 : mod400 + 9'd1;
    end
    if (cmd.month_step) begin
      days <= days - 16'(mon_span);
      mon  <= mon + 4'd1;
    end
  end

  // Hold the finished transaction while the next one is worked on
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      year   <= work_year;
      month  <= mon + 4'd1;
      day    <= days[4:0] + 5'd1;
      hour   <= work_hour;
      minute <= work_min;
      second <= work_sec;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/e2c_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// e2c_ctrl
// Sequencer of the epoch to calendar date converter: input handshake,
// divide passes, year and month walks, output handshake.
// ----------------------------------------------------------------------------
module e2c_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output e2c_pkg::e2c_cmd_t      cmd,
  input  wire e2c_pkg::e2c_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_MUL,
    S_DIV_REM,
    S_YEAR,
    S_MONTH,
    S_FINISH
  } state_t;

  state_t            state;
  e2c_pkg::div_sel_t div_sel;
  logic              accept;
  logic              publish;

  assign accept  = (state == S_IDLE) && in_valid && !in_stall;
  assign publish = (state == S_FINISH) && (!out_valid || !out_stall);

  // Decode commands from state and datapath status
  always_comb begin
    cmd.load       = accept;
    cmd.div_mul    = state == S_DIV_MUL;
    cmd.div_rem    = state == S_DIV_REM;
    cmd.div_sel    = div_sel;
    cmd.year_step  = (state == S_YEAR) && !sts.year_fit;
    cmd.month_step = (state == S_MONTH) && !sts.month_fit;
    cmd.publish    = publish;
  end

  // Hold state, pass counter and handshake outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_sel   <= e2c_pkg::DIV_SEC;
      in_stall  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Drop the result once the receiver takes it
      if (out_valid && !out_stall && !publish) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state    <= S_DIV_MUL;
            div_sel  <= e2c_pkg::DIV_SEC;
            in_stall <= 1'b1;
          end
        end
        S_DIV_MUL: begin
          state <= S_DIV_REM;
        end
        S_DIV_REM: begin
          unique case (div_sel)
            e2c_pkg::DIV_SEC: begin
              div_sel <= e2c_pkg::DIV_MIN;
              state   <= S_DIV_MUL;
            end
            e2c_pkg::DIV_MIN: begin
              div_sel <= e2c_pkg::DIV_HOUR;
              state   <= S_DIV_MUL;
            end
            default: begin
              state <= S_YEAR;
            end
          endcase
        end
        S_YEAR: begin
          if (sts.year_fit) begin
            state <= S_MONTH;
          end
        end
        S_MONTH: begin
          if (sts.month_fit) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (publish) begin
            out_valid <= 1'b1;
            in_stall  <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/epoch_to_calendar_date.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// epoch_to_calendar_date
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 into the UTC
// Gregorian date and time of day.
// Input channel: in_valid / in_stall with epoch_seconds. Output channel:
// out_valid / out_stall with year, month, day, hour, minute, second. A
// transaction moves at a rising edge with valid high and stall low.
// One transaction is converted at a time: three reciprocal-multiply divide
// passes (a multiply step, then a remainder step), then one year per cycle
// from 1970 and one month per cycle from January; the slowest case is
// December 2105. in_stall is high from acceptance until the result enters
// the output register, so a new transaction is not taken before the last
// one is finished.
// If the receiver stalls with a result still held, a finished conversion
// waits in its last step until the output register is taken.
// Reset (rst, synchronous) empties the output register and returns to idle.
// ----------------------------------------------------------------------------
module epoch_to_calendar_date (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] epoch_seconds,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [11:0]      year,
  output logic [3:0]       month,
  output logic [4:0]       day,
  output logic [4:0]       hour,
  output logic [5:0]       minute,
  output logic [5:0]       second
);

  e2c_pkg::e2c_cmd_t cmd;
  e2c_pkg::e2c_sts_t sts;

  // Sequence the conversion
  e2c_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Arithmetic and result registers
  e2c_datapath u_datapath (
    .clk           (clk),
    .epoch_seconds (epoch_seconds),
    .cmd           (cmd),
    .sts           (sts),
    .year          (year),
    .month         (month),
    .day           (day),
    .hour          (hour),
    .minute        (minute),
    .second        (second)
  );

endmodule
`default_nettype wire

/* hw/rtl/e2c_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// e2c_checker
// Port-level checks of the epoch to calendar date converter, bound to the
// top level.
// ----------------------------------------------------------------------------
`include "epoch_to_calendar_date_assert.svh"

module e2c_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [11:0] year,
  input wire logic [3:0]  month,
  input wire logic [4:0]  day,
  input wire logic [4:0]  hour,
  input wire logic [5:0]  minute,
  input wire logic [5:0]  second
);

  logic [37:0] out_data;
  logic        date_ok;
  logic        time_ok;

  // Gather the result payload and its range checks
  assign out_data = {year, month, day, hour, minute, second};
  assign date_ok  = (month >= 4'd1) && (month <= 4'd12) && (day >= 5'd1) &&
                    (year >= 12'd1970) && (year <= 12'd2106);
  assign time_ok  = (hour < 5'd24) && (minute < 6'd60) && (second < 6'd60);

  // A held result keeps its payload while stalled
  `E2C_ASSERT_NEXT(a_hold_result, out_valid && out_stall, out_valid && $stable(out_data))

  // One transaction at a time: accepting closes the input
  `E2C_ASSERT_NEXT(a_single_item, in_valid && !in_stall, in_stall)

  // Date fields stay in calendar range
  `E2C_ASSERT_SAME(a_date_range, out_valid, date_ok)

  // Time-of-day fields stay in range
  `E2C_ASSERT_SAME(a_time_range, out_valid, time_ok)

  // February never reaches day 30
  `E2C_ASSERT_SAME(a_feb_days, out_valid && (month == 4'd2), day <= 5'd29)

endmodule

bind epoch_to_calendar_date e2c_checker u_e2c_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .year      (year),
  .month     (month),
  .day       (day),
  .hour      (hour),
  .minute    (minute),
  .second    (second)
);
`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// Epoch to calendar date testbench
// Drives 32-bit epoch seconds into the converter and checks every date and
// time of day against the bench's behavioral calendar or hand-given values.
// A short table of boundary dates runs first, then random transactions under
// several idle and stall mixes, a long receiver hold-off and drained pauses.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned EPOCH_YEAR   = 1970;
  localparam int unsigned SECS_PER_DAY = 86400;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } cal_date_t;

  typedef struct {
    logic [31:0] epoch;
    cal_date_t   date;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] epoch_seconds;
  logic        out_valid;
  logic        out_stall;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;

  cal_date_t pending_dates[$];
  stim_row_t boundary_table[$];
  cal_date_t seen_date;
  cal_date_t want_date;
  int        error_count    = 0;
  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;
  int        hold_cycles    = 0;

  epoch_to_calendar_date DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .epoch_seconds(epoch_seconds),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .year         (year),
    .month        (month),
    .day          (day),
    .hour         (hour),
    .minute       (minute),
    .second       (second)
  );

  // Gregorian leap rule
  function automatic bit is_leap(input int unsigned yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  // Calendar date and time of day for a count of seconds since 1970
  function automatic cal_date_t date_of_epoch(input logic [31:0] secs);
    int unsigned days_in_month[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    cal_date_t   d;
    int unsigned t;
    int unsigned days;
    int unsigned yr;
    int unsigned mon;
    int unsigned span;
    t        = secs;
    d.second = 6'(t % 60);
    t        = t / 60;
    d.minute = 6'(t % 60);
    t        = t / 60;
    d.hour   = 5'(t % 24);
    days     = t / 24;
    // strip whole years
    yr   = EPOCH_YEAR;
    span = is_leap(yr) ? 366 : 365;
    while (days >= span) begin
      days -= span;
      yr++;
      span = is_leap(yr) ? 366 : 365;
    end
    // strip whole months, never past December
    mon  = 0;
    span = days_in_month[0];
    while (mon < 11 && days >= span) begin
      days -= span;
      mon++;
      span = (mon == 1 && is_leap(yr)) ? 29 : days_in_month[mon];
    end
    d.year  = 12'(yr);
    d.month = 4'(mon + 1);
    d.day   = 5'(days + 1);
    return d;
  endfunction

  // Mostly uniform epochs, with weight on midnights and both ends of the range
  function automatic logic [31:0] random_epoch();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return $urandom();
      6, 7:             return $urandom_range(49710) * SECS_PER_DAY + $urandom_range(2) - 1;
      8:                return $urandom_range(4 * 31536000);
      default:          return 32'hFFFF_FFFF - $urandom_range(40_000_000);
    endcase
  endfunction

  task automatic add_row(input logic [31:0] epoch);
    stim_row_t r;
    r.epoch = epoch;
    r.date  = date_of_epoch(epoch);
    boundary_table.push_back(r);
  endtask

  task automatic add_known(input logic [31:0] epoch, input int unsigned yr,
                           input int unsigned mo, input int unsigned dy,
                           input int unsigned hr, input int unsigned mi,
                           input int unsigned se);
    stim_row_t r;
    r.epoch = epoch;
    r.date  = {12'(yr), 4'(mo), 5'(dy), 5'(hr), 6'(mi), 6'(se)};
    boundary_table.push_back(r);
  endtask

  // Offer one transaction, hold it until accepted, then queue its date
  task automatic send_epoch(input logic [31:0] value, input cal_date_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    epoch_seconds <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    pending_dates.push_back(want);
  endtask

  // Drop valid and wait until every queued date has come back
  task automatic drain_pending();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_dates.size() != 0) @(negedge clk);
  endtask

  task automatic run_random(input int count, input int idle_pct, input int stall_pct);
    logic [31:0] value;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      value = random_epoch();
      send_epoch(value, date_of_epoch(value));
    end
    drain_pending();
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Time limit
  initial begin
    #16_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Receiver: random stalls, or a counted hold-off when one is requested
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Compare each accepted result with the oldest queued date
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen_date = {year, month, day, hour, minute, second};
      if (pending_dates.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d-%0d-%0d %0d:%0d:%0d",
                 $time, year, month, day, hour, minute, second);
        error_count++;
      end else begin
        want_date = pending_dates.pop_front();
        check_field("year", 32'(want_date.year), 32'(seen_date.year));
        check_field("month", 32'(want_date.month), 32'(seen_date.month));
        check_field("day", 32'(want_date.day), 32'(seen_date.day));
        check_field("hour", 32'(want_date.hour), 32'(seen_date.hour));
        check_field("minute", 32'(want_date.minute), 32'(seen_date.minute));
        check_field("second", 32'(want_date.second), 32'(seen_date.second));
      end
    end
  end

  // Stimulus
  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    epoch_seconds = 32'd0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // epoch start, range ends and the signed 32-bit rollover
    add_known(32'd0,          1970, 1, 1, 0, 0, 0);
    add_known(32'd59,         1970, 1, 1, 0, 0, 59);
    add_known(32'd86399,      1970, 1, 1, 23, 59, 59);
    add_known(32'd2147483647, 2038, 1, 19, 3, 14, 7);
    add_known(32'hFFFF_FFFF,  2106, 2, 7, 6, 28, 15);
    // minute, hour and day carries
    add_row(32'd60);
    add_row(32'd3599);
    add_row(32'd3600);
    add_row(32'd86400);
    // month and year turnover in 1970
    add_row(32'd2678399);
    add_row(32'd2678400);
    add_row(32'd31535999);
    add_row(32'd31536000);
    // leap day in 1972 and in 2000
    add_row(32'd68083200);
    add_row(32'd68169600);
    add_row(32'd68256000);
    add_row(32'd951782400);
    add_row(32'd978220799);
    // 2100 is a century year without a leap day
    add_row(32'd4107542399);
    add_row(32'd4107542400);
    // last year turnover within range
    add_row(32'd4291747199);
    add_row(32'd4291747200);
    // alternating and top bit patterns
    add_row(32'h8000_0000);
    add_row(32'hAAAA_AAAA);
    add_row(32'h5555_5555);

    foreach (boundary_table[i]) send_epoch(boundary_table[i].epoch, boundary_table[i].date);
    drain_pending();

    run_random(400, 0, 0);
    // long receiver hold-off while the sender keeps offering transactions
    hold_cycles = 800;
    run_random(12, 0, 0);
    run_random(400, 57, 0);
    run_random(400, 0, 57);
    run_random(400, 14, 14);
    run_random(20, 0, 0);

    // let any stray result surface
    repeat (200) @(posedge clk);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
